/* rtl/assert_macros.svh */
// ============================================================================
// Assertion macros
// Shared concurrent assertion wrappers for the terminal key decoder RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/tked_pkg.sv */
// ============================================================================
// Terminal key decoder package
// Escape modes, action codes and byte constants for the key decoder.
// ============================================================================
`default_nettype none

package tked_pkg;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESC    = 2'd1,
		MODE_CSI    = 2'd2,
		MODE_SS3    = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ACT_NONE      = 4'd0,
		ACT_BOL       = 4'd1,
		ACT_EOL       = 4'd2,
		ACT_DELETE    = 4'd3,
		ACT_BACKSPACE = 4'd4,
		ACT_BACKWORD  = 4'd5,
		ACT_COMPLETE  = 4'd6,
		ACT_ENTER     = 4'd7,
		ACT_UP        = 4'd8,
		ACT_DOWN      = 4'd9,
		ACT_LEFT      = 4'd10,
		ACT_RIGHT     = 4'd11,
		ACT_INSERT    = 4'd12
	} action_t;

	localparam int unsigned PARAM_W = 16;

	// Control characters
	localparam logic [7:0] CH_CTRL_A = 8'd1;
	localparam logic [7:0] CH_CTRL_D = 8'd4;
	localparam logic [7:0] CH_CTRL_E = 8'd5;
	localparam logic [7:0] CH_BS     = 8'd8;
	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_LF     = 8'd10;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_CTRL_W = 8'd23;
	localparam logic [7:0] CH_ESC    = 8'd27;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_DEL    = 8'd127;
	localparam logic [7:0] CH_CSI    = 8'd155;

	// Sequence characters
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_UPPER_O  = 8'h4F;
	localparam logic [7:0] CH_TILDE    = 8'h7E;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_B  = 8'h42;
	localparam logic [7:0] CH_UPPER_C  = 8'h43;
	localparam logic [7:0] CH_UPPER_D  = 8'h44;
	localparam logic [7:0] CH_UPPER_E  = 8'h45;
	localparam logic [7:0] CH_UPPER_F  = 8'h46;
	localparam logic [7:0] CH_UPPER_H  = 8'h48;

	// Tilde sequence parameters
	localparam logic [PARAM_W-1:0] TILDE_HOME = 16'd1;
	localparam logic [PARAM_W-1:0] TILDE_DEL  = 16'd3;
	localparam logic [PARAM_W-1:0] TILDE_END  = 16'd4;

endpackage

`default_nettype wire

/* rtl/tked_if.sv */
// ============================================================================
// Terminal key decoder channels
// Valid/ready channels for received bytes and for decoded actions.
// ============================================================================
`default_nettype none

interface tked_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface tked_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] action;
	logic [7:0] insert_char;

	modport source (output valid, output action, output insert_char, input ready);
	modport sink (input valid, input action, input insert_char, output ready);
endinterface

`default_nettype wire

/* rtl/terminal_key_escape_decoder.sv */
// ============================================================================
// Terminal key escape decoder
// Turns a terminal byte stream into line-editing action requests.
// ============================================================================
//
//  Channel  Direction  Payload                     Per request
//  rx       in         in_byte[7:0]                one received byte
//  act      out        action[3:0], insert_char    one decoded action
//
//  One request is taken per clock cycle while act is not stalled.
//  A byte taken on rx sits in stage one, is decoded into stage two
//  and is then offered on act.
//  The rate is set by the escape state register, which is read and
//  written in the decode cycle so each byte sees its predecessor's state.
//  Reset puts the decoder in normal mode with a zero parameter.
//  A stall on act holds stage two and the escape state; stage one still
//  takes one more request if it is empty, and after that rx.ready drops.
//
`default_nettype none
`include "assert_macros.svh"

module terminal_key_escape_decoder (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tked_in_if.sink      rx,
	tked_out_if.source   act
);

	import tked_pkg::*;

	// Stage one holds the received byte.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Stage two is the result register seen on the act channel.
	logic       valid_s2;
	action_t    action_s2;
	logic [7:0] char_s2;

	// Escape state, updated as a byte moves from stage one to stage two.
	mode_t              mode_q;
	logic [PARAM_W-1:0] param_q;

	// The whole pipe moves when the result register is free or being taken.
	logic advance;
	logic decode_en;

	assign advance   = !valid_s2 || act.ready;
	assign decode_en = valid_s1 && advance;
	assign rx.ready  = !valid_s1 || advance;

	// ------------------------------------------------------------------
	// Decode of one byte against the current escape state
	// ------------------------------------------------------------------
	logic               is_digit;
	logic [PARAM_W+3:0] param_ext;
	logic [PARAM_W-1:0] param_acc;
	mode_t              mode_d;
	logic [PARAM_W-1:0] param_d;
	action_t            action_d;
	logic [7:0]         char_d;

	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);

	// Decimal accumulation: ten times the parameter is eight times plus two
	// times, and the digit is the low nibble of its character code.
	assign param_ext = {1'b0, param_q, 3'b000} + {3'b000, param_q, 1'b0}
		+ {{PARAM_W{1'b0}}, byte_s1[3:0]};
	assign param_acc = (param_ext[PARAM_W+3:PARAM_W] != 4'd0)
		? {PARAM_W{1'b1}} : param_ext[PARAM_W-1:0];

	always_comb begin
		mode_d   = mode_q;
		param_d  = param_q;
		action_d = ACT_NONE;
		unique case (mode_q)
			MODE_NORMAL: begin
				unique case (byte_s1)
					CH_CTRL_A: action_d = ACT_BOL;
					CH_CTRL_D: action_d = ACT_DELETE;
					CH_CTRL_E: action_d = ACT_EOL;
					CH_TAB:    action_d = ACT_COMPLETE;
					CH_LF,
					CH_CR:     action_d = ACT_ENTER;
					CH_CTRL_W: action_d = ACT_BACKWORD;
					CH_BS,
					CH_DEL:    action_d = ACT_BACKSPACE;
					CH_ESC:    mode_d = MODE_ESC;
					CH_CSI: begin
						// The single-byte introducer behaves as ESC [ does.
						mode_d  = MODE_CSI;
						param_d = '0;
					end
					default: begin
						if (byte_s1 >= CH_SPACE) begin
							action_d = ACT_INSERT;
						end
					end
				endcase
			end
			MODE_ESC: begin
				// Nothing is reported for the byte after ESC.
				priority if (byte_s1 == CH_LBRACKET) begin
					mode_d  = MODE_CSI;
					param_d = '0;
				end else if (byte_s1 == CH_UPPER_O) begin
					mode_d  = MODE_SS3;
					param_d = '0;
				end else begin
					mode_d = MODE_NORMAL;
				end
			end
			MODE_CSI: begin
				if (is_digit) begin
					param_d = param_acc;
				end else begin
					mode_d = MODE_NORMAL;
					unique case (byte_s1)
						CH_UPPER_A,
						CH_UPPER_F: action_d = ACT_UP;
						CH_UPPER_B,
						CH_UPPER_E: action_d = ACT_DOWN;
						CH_UPPER_D: action_d = ACT_LEFT;
						CH_UPPER_C: action_d = ACT_RIGHT;
						CH_TILDE: begin
							// Home, delete and end keys by their numeric code.
							priority if (param_q == TILDE_HOME) begin
								action_d = ACT_BOL;
							end else if (param_q == TILDE_DEL) begin
								action_d = ACT_DELETE;
							end else if (param_q == TILDE_END) begin
								action_d = ACT_EOL;
							end else begin
								action_d = ACT_NONE;
							end
						end
						default: action_d = ACT_NONE;
					endcase
				end
			end
			MODE_SS3: begin
				mode_d = MODE_NORMAL;
				priority if (byte_s1 == CH_UPPER_F) begin
					action_d = ACT_EOL;
				end else if (byte_s1 == CH_UPPER_H) begin
					action_d = ACT_BOL;
				end else begin
					action_d = ACT_NONE;
				end
			end
			default: mode_d = MODE_NORMAL;
		endcase
	end

	// The byte is carried only with an insert; every other action reads zero.
	assign char_d = (action_d == ACT_INSERT) ? byte_s1 : 8'd0;

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			mode_q   <= MODE_NORMAL;
			param_q  <= '0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (decode_en) begin
				mode_q  <= mode_d;
				param_q <= param_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.in_byte;
		end
		if (decode_en) begin
			action_s2 <= action_d;
			char_s2   <= char_d;
		end
	end

	assign act.valid       = valid_s2;
	assign act.action      = action_s2;
	assign act.insert_char = char_s2;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`ASSERT_NEVER(a_char_only_on_insert, clk, arst_n,
		valid_s2 && (action_s2 != ACT_INSERT) && (char_s2 != 8'd0),
		"insert_char set without an insert action")
	`ASSERT_CLK(a_state_held_on_stall, clk, arst_n,
		(valid_s2 && !act.ready) |=> ($stable(mode_q) && $stable(param_q)),
		"escape state changed while the result was stalled")
	`ASSERT_CLK(a_esc_enters_esc_mode, clk, arst_n,
		(decode_en && (mode_q == MODE_NORMAL) && (byte_s1 == CH_ESC)) |=> (mode_q == MODE_ESC),
		"ESC in normal mode did not enter escape mode")

endmodule

`default_nettype wire
